[rtl/core/psi5afm_pkg.sv]
package psi5afm_pkg;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 64;
   localparam int NUM_CH      = 3;
   localparam int ACCEL_W     = 15;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic       REG_IDX_EXPECTED = 1'b0;
   localparam logic [15:0] EXPECTED_RESET  = 16'hEF00;

   localparam logic [1:0] LAMP_OFF      = 2'd0;
   localparam logic [1:0] LAMP_WARN     = 2'd2;
   localparam logic [1:0] DIAL_AVAIL    = 2'd1;
   localparam logic [1:0] DIAL_UNAVAIL  = 2'd2;
   localparam logic [7:0] LED_RL_FAULT  = 8'hE7;
   localparam logic [7:0] LED_OK        = 8'hFF;

   localparam int        VALID_BIT = 11;
   localparam logic [9:0] POS_MAX  = 10'h1E0;
   localparam logic [9:0] NEG_MIN  = 10'h220;

   // round(m * 9810 / 300) == floor((m * 327 + 5) / 10), division by 10 via
   // reciprocal 104858 / 2^20, exact for the code range
   localparam logic [25:0] SCALE_MUL = 26'd34288566;
   localparam logic [34:0] SCALE_ADD = 35'd524290;
   localparam int          SCALE_SHR = 20;

   typedef struct packed {
      logic                             mismatch;
      logic                             wheel_any;
      logic [NUM_CH-1:0]                valid;
      logic [NUM_CH-1:0][ACCEL_W-1:0]   accel;
   } round_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/core/psi5afm_front.sv]
module psi5afm_front (
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [psi5afm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [15:0]                            expected_word,
   input  psi5afm_pkg::queue_status_type          q_status,
   output logic                                   push,
   output psi5afm_pkg::round_entry_type           push_entry
);

   function automatic logic [psi5afm_pkg::ACCEL_W-1:0] decode_frame(input logic [15:0] frame);
      logic [9:0]  code;
      logic [8:0]  mag;
      logic        neg;
      logic [34:0] prod;
      logic [psi5afm_pkg::ACCEL_W-1:0] scaled;
      for (int i = 0; i < 10; i++) begin
         code[i] = frame[9-i];
      end
      neg = 1'b0;
      mag = 9'd0;
      if (code <= psi5afm_pkg::POS_MAX) begin
         mag = code[8:0];
      end else if (code >= psi5afm_pkg::NEG_MIN) begin
         mag = (~code[8:0]) + 9'd1;
         neg = 1'b1;
      end
      prod   = 35'(mag) * 35'(psi5afm_pkg::SCALE_MUL) + psi5afm_pkg::SCALE_ADD;
      scaled = prod[psi5afm_pkg::SCALE_SHR +: psi5afm_pkg::ACCEL_W];
      return neg ? (~scaled + 15'd1) : scaled;
   endfunction

   logic [15:0] frames [psi5afm_pkg::NUM_CH];

   assign frames[0] = req_tdata[31:16];
   assign frames[1] = req_tdata[47:32];
   assign frames[2] = req_tdata[63:48];

   assign req_tready = ~q_status.full & ~reset;
   assign push       = req_tvalid & req_tready;

   always_comb begin
      push_entry.mismatch  = (req_tdata[15:0] != expected_word);
      push_entry.wheel_any = |req_tdata[66:64];
      for (int ch = 0; ch < psi5afm_pkg::NUM_CH; ch++) begin
         push_entry.valid[ch] = frames[ch][psi5afm_pkg::VALID_BIT];
         push_entry.accel[ch] = decode_frame(frames[ch]);
      end
   end

endmodule

[rtl/core/psi5afm_queue.sv]
module psi5afm_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  psi5afm_pkg::round_entry_type  push_entry,
   input  logic                          pop,
   output psi5afm_pkg::round_entry_type  head_entry,
   output psi5afm_pkg::queue_status_type q_status
);

   psi5afm_pkg::round_entry_type slot_ff [psi5afm_pkg::QUEUE_DEPTH];
   logic [psi5afm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [psi5afm_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [psi5afm_pkg::QCNT_W-1:0] count_ff, count_in;

   function automatic logic [psi5afm_pkg::QPTR_W-1:0] next_ptr(
      input logic [psi5afm_pkg::QPTR_W-1:0] p);
      if (p == psi5afm_pkg::QPTR_W'(psi5afm_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + psi5afm_pkg::QPTR_W'(1);
   endfunction

   assign q_status.full  = (count_ff == psi5afm_pkg::QCNT_W'(psi5afm_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_entry     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + psi5afm_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - psi5afm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/psi5afm_back.sv]
module psi5afm_back (
   input  logic                               clock,
   input  logic                               reset,
   input  psi5afm_pkg::round_entry_type       head_entry,
   input  psi5afm_pkg::queue_status_type      q_status,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [psi5afm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [psi5afm_pkg::NUM_CH-1:0][psi5afm_pkg::ACCEL_W-1:0] held_ff, held_in;
   logic [psi5afm_pkg::NUM_CH-1:0] faults_ff, faults_in;
   logic                           warn_ff, warn_in;
   logic                           forced;
   logic                           rsp_valid_ff;
   logic [psi5afm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign pop        = ~q_status.empty & (~rsp_valid_ff | rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // channels in order; later channels see earlier fault updates
   always_comb begin
      held_in   = held_ff;
      faults_in = faults_ff;
      warn_in   = warn_ff;
      forced    = 1'b0;
      for (int ch = 0; ch < psi5afm_pkg::NUM_CH; ch++) begin
         if (!head_entry.valid[ch]) begin
            if (faults_in == '0 && !head_entry.wheel_any) begin
               warn_in = 1'b1;
               forced  = 1'b1;
            end
            faults_in[ch] = 1'b1;
         end else begin
            held_in[ch] = head_entry.accel[ch];
            if (faults_in == (psi5afm_pkg::NUM_CH'(1) << ch) && !head_entry.wheel_any) begin
               warn_in = 1'b0;
            end
            faults_in[ch] = 1'b0;
         end
      end
      rsp_data_in = {1'b0,
                     faults_in[2] ? psi5afm_pkg::LED_RL_FAULT : psi5afm_pkg::LED_OK,
                     forced,
                     warn_in ? psi5afm_pkg::DIAL_UNAVAIL : psi5afm_pkg::DIAL_AVAIL,
                     warn_in,
                     warn_in ? psi5afm_pkg::LAMP_WARN : psi5afm_pkg::LAMP_OFF,
                     head_entry.mismatch,
                     faults_in,
                     held_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         faults_ff    <= '0;
         warn_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            held_ff   <= held_in;
            faults_ff <= faults_in;
            warn_ff   <= warn_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[rtl/core/psi5_accel_frame_fault_monitor_top.sv]
// channel | dir      | width | contents
// req     | in       | 72    | one polling round: status word, three frames, wheel faults
// rsp     | out      | 64    | held accelerations, faults, status and lamp/dial outputs
// csr     | in/out   | 32    | APB: expected_status_word at byte address 0
//
// One round per cycle unless rsp stalls; requests reach rsp via the queue and rsp register.
// The front decodes all three frames in the accept cycle (one 9x26 multiply per lane).
// A two-entry queue sits between front and back; rsp stall fills it, then req_tready drops.
// Reset clears the queue, held accelerations, faults and lamp state, and restores the
// status compare value to 0xEF00.
module psi5_accel_frame_fault_monitor_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] status_word, [31:16] frame_front_left, [47:32] frame_front_right,
   // [63:48] frame_rear_left, [64] wheel_fault_fl, [65] wheel_fault_fr,
   // [66] wheel_fault_rl, [71:67] zero
   input  logic [psi5afm_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [14:0] accel_front_left, [29:15] accel_front_right, [44:30] accel_rear_left,
   // [45] fault_front_left, [46] fault_front_right, [47] fault_rear_left,
   // [48] status_mismatch, [50:49] warning_lamp_state, [51] fault_marker,
   // [53:52] dial_state, [54] force_mode_off, [62:55] led_pattern, [63] zero
   output logic [psi5afm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [psi5afm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [psi5afm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [psi5afm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                csr_pready
);

   logic [15:0] expected_ff, expected_in;
   logic        csr_hit;
   logic        push;
   logic        pop;
   psi5afm_pkg::round_entry_type  push_entry;
   psi5afm_pkg::round_entry_type  head_entry;
   psi5afm_pkg::queue_status_type q_status;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == psi5afm_pkg::REG_IDX_EXPECTED);
   assign csr_prdata = csr_hit ? {16'd0, expected_ff} : '0;

   always_comb begin
      expected_in = expected_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         expected_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= psi5afm_pkg::EXPECTED_RESET;
      end else begin
         expected_ff <= expected_in;
      end
   end

   psi5afm_front u_front (
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .expected_word (expected_ff),
      .q_status      (q_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   psi5afm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   psi5afm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_forced_implies_warn: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[54]) |-> (rsp_tdata[50:49] == psi5afm_pkg::LAMP_WARN))
      else $error("fault entry without warning lamp");

   a_lamp_dial_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (((rsp_tdata[50:49] == psi5afm_pkg::LAMP_WARN)
                       == (rsp_tdata[53:52] == psi5afm_pkg::DIAL_UNAVAIL))
                      && (rsp_tdata[51] == (rsp_tdata[50:49] == psi5afm_pkg::LAMP_WARN))))
      else $error("lamp, marker and dial disagree");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("queue overrun");

endmodule

[tb/tb_psi5_accel_frame_fault_monitor_top.sv]
`timescale 1ns / 1ps

module tb_psi5_accel_frame_fault_monitor_top;

   localparam int ACCEL_NUM      = 9810;
   localparam int ACCEL_DEN      = 300;
   localparam logic [9:0] NEG_MAG_MASK = 10'h1FF;
   localparam int REG_IDX_UNUSED = 1;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 500000;

   typedef struct packed {
      logic [4:0]  pad;
      logic        wheel_rl;
      logic        wheel_fr;
      logic        wheel_fl;
      logic [15:0] frame_rl;
      logic [15:0] frame_fr;
      logic [15:0] frame_fl;
      logic [15:0] status_word;
   } accel_round_type;

   typedef struct packed {
      logic        pad;
      logic [7:0]  led_pattern;
      logic        force_mode_off;
      logic [1:0]  dial_state;
      logic        fault_marker;
      logic [1:0]  warning_lamp_state;
      logic        status_mismatch;
      logic        fault_rl;
      logic        fault_fr;
      logic        fault_fl;
      logic [14:0] accel_rl;
      logic [14:0] accel_fr;
      logic [14:0] accel_fl;
   } accel_report_type;

   typedef struct {
      accel_round_type round;
      int              gap;
      bit              drain;
   } pending_round_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [psi5afm_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [psi5afm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [psi5afm_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [psi5afm_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [psi5afm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   psi5_accel_frame_fault_monitor_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // predicted block state
   logic [15:0]        status_ref  = psi5afm_pkg::EXPECTED_RESET;
   logic signed [14:0] held_accel [3] = '{default: '0};
   logic [2:0]         fault_state = '0;
   logic [1:0]         lamp_state  = psi5afm_pkg::LAMP_OFF;
   logic               marker_state = 1'b0;
   logic [1:0]         dial_state  = psi5afm_pkg::DIAL_AVAIL;

   pending_round_type round_queue [$];
   accel_report_type  report_queue [$];
   int  rounds_queued = 0;
   int  rounds_sent = 0;
   int  error_total = 0;
   int  cycle_count = 0;
   bit  req_fire = 1'b0;
   bit  sender_idle_on = 1'b1;
   bit  receiver_idle_on = 1'b1;
   int  hold_tickets = 0;
   int  hold_served = 0;
   int  hold_left = 0;
   int  stall_left = 0;

   function automatic logic [9:0] flip10(logic [9:0] v);
      logic [9:0] r;
      for (int i = 0; i < 10; i++) r[i] = v[9 - i];
      return r;
   endfunction

   function automatic logic signed [14:0] accel_from_frame(logic [15:0] frame);
      logic [9:0] code;
      int mag;
      int scaled;
      code = flip10(frame[9:0]);
      if (code <= psi5afm_pkg::POS_MAX) begin
         scaled = (int'(code) * ACCEL_NUM * 2 + ACCEL_DEN) / (2 * ACCEL_DEN);
         return 15'(scaled);
      end
      if (code >= psi5afm_pkg::NEG_MIN) begin
         mag = int'((~code) & NEG_MAG_MASK) + 1;
         scaled = (mag * ACCEL_NUM * 2 + ACCEL_DEN) / (2 * ACCEL_DEN);
         return 15'(-scaled);
      end
      return '0;
   endfunction

   function automatic accel_report_type predict_report(accel_round_type r);
      accel_report_type res;
      logic [15:0] frames [3];
      logic wheel_any;
      logic forced;
      frames[0] = r.frame_fl;
      frames[1] = r.frame_fr;
      frames[2] = r.frame_rl;
      wheel_any = r.wheel_fl | r.wheel_fr | r.wheel_rl;
      forced = 1'b0;
      for (int ch = 0; ch < psi5afm_pkg::NUM_CH; ch++) begin
         if (!frames[ch][psi5afm_pkg::VALID_BIT]) begin
            if (fault_state == 3'b000 && !wheel_any) begin
               lamp_state = psi5afm_pkg::LAMP_WARN;
               marker_state = 1'b1;
               dial_state = psi5afm_pkg::DIAL_UNAVAIL;
               forced = 1'b1;
            end
            fault_state[ch] = 1'b1;
         end else begin
            held_accel[ch] = accel_from_frame(frames[ch]);
            if (fault_state == (3'b001 << ch) && !wheel_any) begin
               lamp_state = psi5afm_pkg::LAMP_OFF;
               marker_state = 1'b0;
               dial_state = psi5afm_pkg::DIAL_AVAIL;
            end
            fault_state[ch] = 1'b0;
         end
      end
      res = '0;
      res.accel_fl = held_accel[0];
      res.accel_fr = held_accel[1];
      res.accel_rl = held_accel[2];
      res.fault_fl = fault_state[0];
      res.fault_fr = fault_state[1];
      res.fault_rl = fault_state[2];
      res.status_mismatch = (r.status_word != status_ref);
      res.warning_lamp_state = lamp_state;
      res.fault_marker = marker_state;
      res.dial_state = dial_state;
      res.force_mode_off = forced;
      res.led_pattern = fault_state[2] ? psi5afm_pkg::LED_RL_FAULT : psi5afm_pkg::LED_OK;
      return res;
   endfunction

   function automatic void check_field(string name, logic signed [31:0] exp_v,
                                       logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         error_total++;
      end
   endfunction

   function automatic void compare_report(accel_report_type exp_r, accel_report_type got);
      check_field("accel_front_left", $signed(exp_r.accel_fl), $signed(got.accel_fl));
      check_field("accel_front_right", $signed(exp_r.accel_fr), $signed(got.accel_fr));
      check_field("accel_rear_left", $signed(exp_r.accel_rl), $signed(got.accel_rl));
      check_field("fault_front_left", exp_r.fault_fl, got.fault_fl);
      check_field("fault_front_right", exp_r.fault_fr, got.fault_fr);
      check_field("fault_rear_left", exp_r.fault_rl, got.fault_rl);
      check_field("status_mismatch", exp_r.status_mismatch, got.status_mismatch);
      check_field("warning_lamp_state", exp_r.warning_lamp_state, got.warning_lamp_state);
      check_field("fault_marker", exp_r.fault_marker, got.fault_marker);
      check_field("dial_state", exp_r.dial_state, got.dial_state);
      check_field("force_mode_off", exp_r.force_mode_off, got.force_mode_off);
      check_field("led_pattern", exp_r.led_pattern, got.led_pattern);
   endfunction

   // accept side: predict on request, check on response
   always @(posedge clock) begin
      accel_report_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_tvalid && req_tready;
         if (req_fire) begin
            report_queue.push_back(predict_report(accel_round_type'(req_tdata)));
            rounds_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = accel_report_type'(rsp_tdata);
            if (report_queue.size() == 0) begin
               $error("unexpected response: %h", rsp_tdata);
               error_total++;
            end else begin
               compare_report(report_queue.pop_front(), got);
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      pending_round_type item;
      if (!reset && (!req_tvalid || req_fire)) begin
         if (round_queue.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (round_queue[0].gap > 0) begin
            round_queue[0].gap = round_queue[0].gap - 1;
            req_tvalid <= 1'b0;
         end else if (round_queue[0].drain && report_queue.size() != 0) begin
            req_tvalid <= 1'b0;
         end else begin
            item = round_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= item.round;
         end
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // response sink
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_served != hold_tickets) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (receiver_idle_on && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [15:0] make_frame(bit valid, logic [9:0] code, logic [4:0] junk);
      return {junk[4:1], valid, junk[0], flip10(code)};
   endfunction

   function automatic int sender_gap();
      if (!sender_idle_on || $urandom_range(0, 99) < 65) return 0;
      return pick_gap();
   endfunction

   task automatic push_round(accel_round_type r, bit drain);
      pending_round_type item;
      item.round = r;
      item.gap = sender_gap();
      item.drain = drain;
      round_queue.push_back(item);
      rounds_queued++;
   endtask

   task automatic push_directed(logic [15:0] status, logic [2:0] valid, logic [9:0] c_fl,
                                logic [9:0] c_fr, logic [9:0] c_rl, logic [2:0] wheel,
                                logic [4:0] junk);
      accel_round_type r;
      r = '0;
      r.status_word = status;
      r.frame_fl = make_frame(valid[0], c_fl, junk);
      r.frame_fr = make_frame(valid[1], c_fr, ~junk);
      r.frame_rl = make_frame(valid[2], c_rl, junk);
      {r.wheel_rl, r.wheel_fr, r.wheel_fl} = wheel;
      push_round(r, 1'b0);
   endtask

   function automatic logic [9:0] random_code();
      if ($urandom_range(0, 99) >= 20) return 10'($urandom_range(0, 1023));
      case ($urandom_range(0, 10))
         0: return 10'h000;
         1: return 10'h001;
         2: return 10'h005;
         3: return psi5afm_pkg::POS_MAX;
         4: return psi5afm_pkg::POS_MAX + 10'd1;
         5: return 10'h200;
         6: return psi5afm_pkg::NEG_MIN - 10'd1;
         7: return psi5afm_pkg::NEG_MIN;
         8: return psi5afm_pkg::NEG_MIN + 10'd1;
         9: return 10'h3FB;
         default: return 10'h3FF;
      endcase
   endfunction

   task automatic push_random(int count);
      accel_round_type r;
      int pick;
      for (int n = 0; n < count; n++) begin
         r = '0;
         pick = $urandom_range(0, 99);
         if (pick < 75) r.status_word = status_ref;
         else if (pick < 85) r.status_word = status_ref ^ (16'h1 << $urandom_range(0, 15));
         else r.status_word = 16'($urandom);
         r.frame_fl = make_frame($urandom_range(0, 99) < 85, random_code(), 5'($urandom));
         r.frame_fr = make_frame($urandom_range(0, 99) < 85, random_code(), 5'($urandom));
         r.frame_rl = make_frame($urandom_range(0, 99) < 85, random_code(), 5'($urandom));
         r.wheel_fl = $urandom_range(0, 99) < 8;
         r.wheel_fr = $urandom_range(0, 99) < 8;
         r.wheel_rl = $urandom_range(0, 99) < 8;
         push_round(r, 1'b0);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (rounds_sent != rounds_queued || report_queue.size() != 0);
   endtask

   task automatic csr_write(int idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= psi5afm_pkg::CSR_ADDR_W'(idx * 4);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      if (idx == int'(psi5afm_pkg::REG_IDX_EXPECTED)) status_ref = value[15:0];
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_check_expected();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= psi5afm_pkg::CSR_ADDR_W'(int'(psi5afm_pkg::REG_IDX_EXPECTED) * 4);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      check_field("expected_status_word", status_ref, csr_prdata[15:0]);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // code extremes, zero band, rounding halves, fault entry/exit, channel order
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b111, 10'h000, 10'h000, 10'h000,
                    3'b000, 5'h00);
      push_directed(16'h0000, 3'b111, psi5afm_pkg::POS_MAX, psi5afm_pkg::NEG_MIN, 10'h3FF,
                    3'b000, 5'h1F);
      push_directed(16'hFFFF, 3'b111, 10'h001, 10'h005, 10'h3FB, 3'b000, 5'h0A);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b111, psi5afm_pkg::POS_MAX + 10'd1,
                    10'h200, psi5afm_pkg::NEG_MIN - 10'd1, 3'b000, 5'h15);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b110, 10'h3FF, 10'h100, 10'h2AA,
                    3'b000, 5'h00);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b111, 10'h155, 10'h100, 10'h2AA,
                    3'b000, 5'h1F);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b101, 10'h0F0, 10'h3FF, 10'h001,
                    3'b010, 5'h00);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b111, 10'h0F0, 10'h30F, 10'h001,
                    3'b000, 5'h00);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b010, 10'h3FF, 10'h0AA, 10'h3FF,
                    3'b000, 5'h1F);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b011, 10'h1E0, 10'h0AA, 10'h3FF,
                    3'b000, 5'h00);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b111, 10'h1E0, 10'h0AA, 10'h222,
                    3'b000, 5'h00);
      push_directed(16'hEF01, 3'b000, 10'h3FF, 10'h3FF, 10'h3FF, 3'b001, 5'h1F);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b111, 10'h010, 10'h020, 10'h040,
                    3'b000, 5'h00);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b000, 10'h3FF, 10'h3FF, 10'h3FF,
                    3'b000, 5'h1F);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b111, 10'h221, 10'h1DF, 10'h3FE,
                    3'b100, 5'h00);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b101, 10'h221, 10'h1DF, 10'h3FE,
                    3'b000, 5'h00);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b111, 10'h080, 10'h300, 10'h003,
                    3'b111, 5'h1F);
      push_directed(16'h7F00, 3'b111, 10'h123, 10'h321, 10'h210, 3'b000, 5'h0F);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b011, 10'h000, 10'h000, 10'h000,
                    3'b000, 5'h10);
      push_directed(psi5afm_pkg::EXPECTED_RESET, 3'b111, 10'h3FF, 10'h000, 10'h1E0,
                    3'b000, 5'h00);
      push_random(300);
      wait_drained();

      // long receiver hold while requests keep coming
      csr_write(int'(psi5afm_pkg::REG_IDX_EXPECTED), 32'h0000_0000);
      csr_check_expected();
      hold_tickets++;
      push_random(300);
      wait_drained();

      // back to back, no idling
      csr_write(int'(psi5afm_pkg::REG_IDX_EXPECTED), 32'h0000_FFFF);
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      push_random(300);
      wait_drained();

      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
      csr_write(REG_IDX_UNUSED, $urandom);
      csr_write(int'(psi5afm_pkg::REG_IDX_EXPECTED), $urandom);
      csr_check_expected();
      push_random(150);
      push_directed(status_ref, 3'b111, random_code(), random_code(), random_code(),
                    3'b000, 5'($urandom));
      round_queue[round_queue.size() - 1].drain = 1'b1;
      push_random(150);
      wait_drained();

      csr_write(int'(psi5afm_pkg::REG_IDX_EXPECTED), {16'h0000, psi5afm_pkg::EXPECTED_RESET});
      csr_check_expected();
      push_random(330);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_total == 0 && report_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/psi5afm_pkg.sv
rtl/core/psi5afm_front.sv
rtl/core/psi5afm_queue.sv
rtl/core/psi5afm_back.sv
rtl/core/psi5_accel_frame_fault_monitor_top.sv
tb/tb_psi5_accel_frame_fault_monitor_top.sv
